/* design/rpe_pkg.sv */
package rpe_pkg;

  localparam int NMAX = 4;
  localparam int DW   = 32;
  localparam int AW   = 52;
  localparam int DVW  = 49;

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [AW-1:0] acc_t;

  localparam logic [16:0] RESET_LAMBDA = 17'd65536;
  localparam logic [30:0] RESET_DELTA  = 31'd65536000;

  localparam logic [2:0] REG_LAMBDA = 3'd0;
  localparam logic [2:0] REG_DELTA  = 3'd1;
  localparam logic [2:0] REG_DEF0   = 3'd2;
  localparam logic [2:0] REG_DEF1   = 3'd3;
  localparam logic [2:0] REG_DEF2   = 3'd4;
  localparam logic [2:0] REG_DEF3   = 3'd5;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  function automatic data_t sat32(input acc_t v);
    if (v > acc_t'(64'sd2147483647)) begin
      return data_t'(32'h7fff_ffff);
    end else if (v < -acc_t'(64'sd2147483648)) begin
      return data_t'(32'h8000_0000);
    end
    return v[DW-1:0];
  endfunction

endpackage

/* design/rls_parameter_estimator.sv */
// Recursive least squares estimator, DIM parameters, signed Q16.16.
// Input stream: s_axis_tuser carries the opcode (update or reset), s_axis_tdata
// the regressor vector and the measured output. Output stream: one item per
// input item with the parameter vector, the prediction and the update count.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i; write
// only while the block is idle.
// The covariance matrix lives in a 16-entry memory with registered read; one
// shared 32x32 multiplier and one radix-2 divider (49 steps) do all the work.
// In an update item the divider dominates; a reset item sweeps all 16 entries
// of the memory. After reset P holds 65536000 on the diagonal, theta is zero
// and the count is zero. A new item is taken once the previous one has reached
// the output register; while the receiver stalls the result holds and at most
// one more item is worked on, then the block waits.
module rls_parameter_estimator #(
  parameter int DIM = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // regressor_0, regressor_1, regressor_2, regressor_3, measured_output
  input  logic [159:0] s_axis_tdata,
  // opcode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // estimate_0, estimate_1, estimate_2, estimate_3, prediction, update_total
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [1:0] LAST = 2'(DIM - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_PPHI, ST_DEN, ST_PRED, ST_KDIV,
    ST_THETA, ST_KPHI, ST_MAC, ST_PDIV, ST_DONE
  } state_e;

  state_e state_q;
  logic [1:0] ph_q;
  logic [1:0] i_q, n_q, jc_q;

  logic [16:0] lam_q;
  logic [30:0] delta_q;
  rpe_pkg::data_t def_q [rpe_pkg::NMAX];

  rpe_pkg::data_t phi_q   [rpe_pkg::NMAX];
  rpe_pkg::data_t theta_q [rpe_pkg::NMAX];
  rpe_pkg::data_t pphi_q  [rpe_pkg::NMAX];
  rpe_pkg::data_t k_q     [rpe_pkg::NMAX];
  rpe_pkg::data_t pcol_q  [rpe_pkg::NMAX];
  rpe_pkg::data_t mcol_q  [rpe_pkg::NMAX];
  rpe_pkg::data_t kphi_q  [16];
  rpe_pkg::data_t y_q, den_q, pred_q, err_q;
  rpe_pkg::acc_t  acc_q;
  logic signed [63:0] prod_q;
  logic [31:0] upd_q;

  // covariance memory
  rpe_pkg::data_t mem_q [16];
  logic [15:0] valid_q;
  rpe_pkg::data_t rd_q;
  logic rdv_q, rdd_q;
  logic [3:0] raddr;
  logic mem_we;
  logic [3:0] mem_waddr;
  rpe_pkg::data_t mem_wdata;
  rpe_pkg::data_t rd_val;

  // divider
  logic dv_run_q, dv_neg_q;
  logic [5:0] dv_cnt_q;
  logic [30:0] dv_rem_q, dv_den_q;
  logic [rpe_pkg::DVW-1:0] dv_quo_q;
  logic signed [rpe_pkg::DVW-1:0] dv_num;
  logic [rpe_pkg::DVW-1:0] dv_mag;
  logic [31:0] dv_shift;
  logic [32:0] dv_trial;
  rpe_pkg::data_t dv_res;
  logic signed [32:0] pdiff;

  logic m_valid_q;
  logic [191:0] m_data_q;

  rpe_pkg::data_t mul_a, mul_b;
  logic signed [47:0] term;
  rpe_pkg::acc_t acc_sum, theta_sum, den_sum, err_diff;
  rpe_pkg::data_t acc_sat;
  logic [16:0] lam_eff;
  logic last_n, last_i, in_acc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign lam_eff = (lam_q == 17'd0) ? 17'd1 : lam_q;
  assign last_n  = (n_q == LAST);
  assign last_i  = (i_q == LAST);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign term      = prod_q[63:16];
  assign acc_sum   = acc_q + rpe_pkg::acc_t'(term);
  assign acc_sat   = rpe_pkg::sat32(acc_sum);
  assign theta_sum = rpe_pkg::acc_t'(theta_q[i_q]) + rpe_pkg::acc_t'(term);
  assign den_sum   = rpe_pkg::acc_t'({1'b0, lam_eff}) + rpe_pkg::acc_t'(acc_sat);
  assign err_diff  = rpe_pkg::acc_t'(y_q) - rpe_pkg::acc_t'(acc_sat);
  assign pdiff     = 33'(pcol_q[i_q]) - 33'(mcol_q[i_q]);

  assign rd_val = rdv_q ? rd_q :
                  (rdd_q ? rpe_pkg::data_t'({1'b0, rpe_pkg::RESET_DELTA}) : '0);

  always_comb begin
    unique case (state_q)
      ST_MAC:  raddr = {n_q, jc_q};
      default: raddr = {i_q, n_q};
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_PPHI: begin
        mul_a = rd_val;
        mul_b = phi_q[n_q];
      end
      ST_DEN: begin
        mul_a = phi_q[i_q];
        mul_b = pphi_q[i_q];
      end
      ST_PRED: begin
        mul_a = phi_q[i_q];
        mul_b = theta_q[i_q];
      end
      ST_THETA: begin
        mul_a = k_q[i_q];
        mul_b = err_q;
      end
      ST_KPHI: begin
        mul_a = k_q[i_q];
        mul_b = phi_q[n_q];
      end
      ST_MAC: begin
        mul_a = kphi_q[{i_q, n_q}];
        mul_b = rd_val;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {i_q, n_q};
    mem_wdata = '0;
    if (state_q == ST_CLR) begin
      mem_we = 1'b1;
      if (i_q == n_q && i_q <= LAST) begin
        mem_wdata = rpe_pkg::data_t'({1'b0, delta_q});
      end
    end else if (state_q == ST_PDIV && ph_q == 2'd1 && !dv_run_q) begin
      mem_we    = 1'b1;
      mem_waddr = {i_q, jc_q};
      mem_wdata = dv_res;
    end
  end

  always_comb begin
    if (state_q == ST_KDIV) begin
      dv_num = {pphi_q[i_q][rpe_pkg::DW-1], pphi_q[i_q], 16'b0};
    end else begin
      dv_num = {pdiff, 16'b0};
    end
    dv_mag   = dv_num[rpe_pkg::DVW-1] ? -dv_num : dv_num;
    dv_shift = {dv_rem_q, dv_quo_q[rpe_pkg::DVW-1]};
    dv_trial = {1'b0, dv_shift} - {2'b0, dv_den_q};
    if (dv_neg_q) begin
      dv_res = (dv_quo_q > rpe_pkg::DVW'(33'h0_8000_0000)) ? rpe_pkg::data_t'(32'h8000_0000)
                                                           : -dv_quo_q[31:0];
    end else begin
      dv_res = (dv_quo_q > rpe_pkg::DVW'(33'h0_7fff_ffff)) ? rpe_pkg::data_t'(32'h7fff_ffff)
                                                           : dv_quo_q[31:0];
    end
  end

  // memory: write port and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q  <= mem_q[raddr];
    rdv_q <= valid_q[raddr];
    rdd_q <= (raddr[3:2] == raddr[1:0]) && (raddr[3:2] <= LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[mem_waddr] <= 1'b1;
    end
  end

  // divider, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_run_q <= 1'b0;
      dv_cnt_q <= '0;
    end else if ((state_q == ST_KDIV || state_q == ST_PDIV) && ph_q == 2'd0 &&
                 !(state_q == ST_KDIV && den_q <= 0)) begin
      dv_run_q <= 1'b1;
      dv_cnt_q <= 6'(rpe_pkg::DVW - 1);
    end else if (dv_run_q) begin
      dv_cnt_q <= dv_cnt_q - 6'd1;
      if (dv_cnt_q == 6'd0) begin
        dv_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!dv_run_q) begin
      dv_rem_q <= '0;
      dv_quo_q <= dv_mag;
      dv_neg_q <= dv_num[rpe_pkg::DVW-1];
      dv_den_q <= (state_q == ST_KDIV) ? den_q[30:0] : {14'b0, lam_eff};
    end else if (!dv_trial[32]) begin
      dv_rem_q <= dv_trial[30:0];
      dv_quo_q <= {dv_quo_q[rpe_pkg::DVW-2:0], 1'b1};
    end else begin
      dv_rem_q <= dv_shift[30:0];
      dv_quo_q <= {dv_quo_q[rpe_pkg::DVW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ph_q      <= '0;
      i_q       <= '0;
      n_q       <= '0;
      jc_q      <= '0;
      m_valid_q <= 1'b0;
      upd_q     <= '0;
      lam_q     <= rpe_pkg::RESET_LAMBDA;
      delta_q   <= rpe_pkg::RESET_DELTA;
      for (int e = 0; e < rpe_pkg::NMAX; e++) begin
        def_q[e]   <= '0;
        theta_q[e] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rpe_pkg::REG_LAMBDA: lam_q    <= cfg_data_i[16:0];
          rpe_pkg::REG_DELTA:  delta_q  <= cfg_data_i[30:0];
          rpe_pkg::REG_DEF0:   def_q[0] <= cfg_data_i;
          rpe_pkg::REG_DEF1:   def_q[1] <= cfg_data_i;
          rpe_pkg::REG_DEF2:   def_q[2] <= cfg_data_i;
          rpe_pkg::REG_DEF3:   def_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            i_q  <= '0;
            n_q  <= '0;
            jc_q <= '0;
            ph_q <= '0;
            acc_q <= '0;
            y_q  <= s_axis_tdata[159:128];
            for (int e = 0; e < rpe_pkg::NMAX; e++) begin
              phi_q[e] <= (e < DIM) ? s_axis_tdata[32*e +: 32] : '0;
            end
            if (s_axis_tuser[0] == rpe_pkg::OP_RESET) begin
              state_q <= ST_CLR;
              upd_q   <= '0;
              pred_q  <= '0;
              for (int e = 0; e < rpe_pkg::NMAX; e++) begin
                theta_q[e] <= (e < DIM) ? def_q[e] : '0;
              end
            end else begin
              state_q <= ST_PPHI;
            end
          end
        end

        ST_CLR: begin
          {i_q, n_q} <= {i_q, n_q} + 4'd1;
          if ({i_q, n_q} == 4'hf) begin
            state_q <= ST_DONE;
          end
        end

        ST_PPHI, ST_KPHI, ST_MAC: begin
          if (ph_q == 2'd1 && state_q == ST_MAC && n_q == i_q) begin
            pcol_q[i_q] <= rd_val;
          end
          if (ph_q == 2'd2) begin
            ph_q <= '0;
            if (state_q == ST_KPHI) begin
              kphi_q[{i_q, n_q}] <= rpe_pkg::sat32(rpe_pkg::acc_t'(term));
            end
            if (last_n) begin
              acc_q <= '0;
              n_q   <= '0;
              if (state_q == ST_PPHI) begin
                pphi_q[i_q] <= acc_sat;
              end
              if (state_q == ST_MAC) begin
                mcol_q[i_q] <= acc_sat;
              end
              if (last_i) begin
                i_q <= '0;
                unique case (state_q)
                  ST_PPHI: state_q <= ST_DEN;
                  ST_KPHI: state_q <= ST_MAC;
                  default: state_q <= ST_PDIV;
                endcase
              end else begin
                i_q <= i_q + 2'd1;
              end
            end else begin
              acc_q <= acc_sum;
              n_q   <= n_q + 2'd1;
            end
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end

        ST_DEN, ST_PRED, ST_THETA: begin
          if (ph_q == 2'd2) begin
            ph_q <= '0;
            if (state_q == ST_THETA) begin
              theta_q[i_q] <= rpe_pkg::sat32(theta_sum);
            end
            if (last_i) begin
              acc_q <= '0;
              i_q   <= '0;
              unique case (state_q)
                ST_DEN: begin
                  den_q   <= rpe_pkg::sat32(den_sum);
                  state_q <= ST_PRED;
                end
                ST_PRED: begin
                  pred_q  <= acc_sat;
                  err_q   <= rpe_pkg::sat32(err_diff);
                  state_q <= ST_KDIV;
                end
                default: state_q <= ST_KPHI;
              endcase
            end else begin
              acc_q <= acc_sum;
              i_q   <= i_q + 2'd1;
            end
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end

        ST_KDIV, ST_PDIV: begin
          if (ph_q == 2'd0) begin
            if (state_q == ST_KDIV && den_q <= 0) begin
              // gain is zero without a positive denominator
              k_q[i_q] <= '0;
              if (last_i) begin
                i_q     <= '0;
                state_q <= ST_THETA;
              end else begin
                i_q <= i_q + 2'd1;
              end
            end else begin
              ph_q <= 2'd1;
            end
          end else if (!dv_run_q) begin
            ph_q <= '0;
            if (state_q == ST_KDIV) begin
              k_q[i_q] <= dv_res;
            end
            if (last_i) begin
              i_q <= '0;
              if (state_q == ST_KDIV) begin
                state_q <= ST_THETA;
              end else if (jc_q == LAST) begin
                upd_q   <= upd_q + 32'd1;
                state_q <= ST_DONE;
              end else begin
                jc_q    <= jc_q + 2'd1;
                n_q     <= '0;
                state_q <= ST_MAC;
              end
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end

        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {upd_q, pred_q, theta_q[3], theta_q[2], theta_q[1], theta_q[0]};
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_mem_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLR || state_q == ST_PDIV))
    else $error("covariance written outside sweep or update");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_run_q |-> (state_q == ST_KDIV || state_q == ST_PDIV))
    else $error("divider running outside a divide step");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result shown without a finished item");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !m_axis_tvalid) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished item not moved to output");
`endif

endmodule
